@@ hdl/rvcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rvcs_pkg: shared types and constants of the small RV32E-subset core
// Word formats, operation codes, instruction encodings and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rvcs_pkg;

  localparam int unsigned MEM_WORDS_DEF = 1024;
  localparam int unsigned REG_COUNT_DEF = 16;

  // pipeline depth of the word-index unit when the depth is not a power of two
  localparam int unsigned AGU_DIV_LAT = 2;

  // item operations
  localparam logic [1:0] FUNC_EXEC   = 2'd0;
  localparam logic [1:0] FUNC_HWRITE = 2'd1;
  localparam logic [1:0] FUNC_HREAD  = 2'd2;

  // trap report
  localparam logic [1:0] TRAP_NONE = 2'd0;
  localparam logic [1:0] TRAP_GOOD = 2'd1;
  localparam logic [1:0] TRAP_BAD  = 2'd2;

  // opcodes and function fields
  localparam logic [6:0] OP_LUI   = 7'h37;
  localparam logic [6:0] OP_ARITH = 7'h33;
  localparam logic [6:0] OP_IMM   = 7'h13;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_JALR  = 7'h67;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_B   = 3'd0;
  localparam logic [2:0] F3_W   = 3'd2;
  localparam logic [2:0] F3_BU  = 3'd4;
  localparam logic [6:0] F7_ADD = 7'd0;

  localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
  localparam int unsigned A0_INDEX    = 10;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  host_addr;
    logic [31:0] host_data;
  } in_t;

  typedef struct packed {
    logic [31:0] pc_now;
    logic [31:0] fetched_inst;
    logic        is_halted;
    logic [1:0]  trap_code;
    logic        unknown_inst;
    logic [31:0] read_data;
  } out_t;

  function automatic logic [31:0] sext12(input logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  function automatic bit is_pow2(input int unsigned v);
    return (v & (v - 1)) == 0;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rv32e_subset_core_step.sv @@
// A depth that is not a power of two puts the index pipeline ahead of fetch, host and
// data accesses. Hand-off: the next word is taken as the current result registers.
// Reset: PC, halt flag and registers clear at once; the word memory is then cleared one
// word per cycle, and no item is taken during that pass.
// ----------------------------------------------------------------------------
// rv32e_subset_core_step: small RV32E-subset core around a word memory
// Sequencer that fetches, decodes, executes and accesses memory for each execute item,
// with host word reads and writes sharing the same memory ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32e_subset_core_step #(
  parameter int unsigned MemWords = rvcs_pkg::MEM_WORDS_DEF,
  parameter int unsigned RegCount = rvcs_pkg::REG_COUNT_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire rvcs_pkg::in_t in_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output rvcs_pkg::out_t     out_word_o
);

  localparam int unsigned AW = $clog2(MemWords);
  localparam int unsigned RW = $clog2(RegCount);
  localparam logic [1:0]  AguLat  = rvcs_pkg::is_pow2(MemWords) ? 2'd0
                                                                : 2'(rvcs_pkg::AGU_DIV_LAT);
  localparam logic [AW-1:0] ClrLast = AW'(MemWords - 1);
  localparam logic [RW-1:0] A0Idx   = RW'(rvcs_pkg::A0_INDEX % RegCount);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_FADDR = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_DWAIT = 4'd5;
  localparam logic [3:0] S_MEM   = 4'd6;
  localparam logic [3:0] S_HADDR = 4'd7;
  localparam logic [3:0] S_HREAD = 4'd8;
  localparam logic [3:0] S_NOP   = 4'd9;

  function automatic logic [RW-1:0] rix(input logic [4:0] f);
    logic [5:0] w;
    w = {1'b0, f};
    if (w >= 6'(RegCount)) begin
      w = w - 6'(RegCount);
    end
    return w[RW-1:0];
  endfunction

  logic [3:0]     state_q, state_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [31:0]    pc_q, pc_d;
  logic           halt_q, halt_d;
  rvcs_pkg::in_t  req_q;
  logic [31:0]    inst_q, inst_d;
  logic [AW-1:0]  widx_q, widx_d;
  rvcs_pkg::out_t out_q, res;
  logic           out_valid_q;

  logic           cnt_ok, out_free, fin, in_ready, in_fire;
  logic [29:0]    agu_word;
  logic [AW-1:0]  agu_idx;

  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [31:0]    mem_wdata, mem_rdata;

  logic           rf_we, rf_re;
  logic [RW-1:0]  rf_waddr, rf_raddr1, rf_raddr2;
  logic [31:0]    rf_wdata, rs1v, rs2v;

  // decode of the held instruction
  logic [6:0]     opc, f7;
  logic [2:0]     f3;
  logic           is_lui, is_add, is_addi, is_lw, is_lbu, is_sw, is_sb, is_jalr;
  logic           is_ebreak, is_mem;
  logic [31:0]    immi, imms, daddr, pc_plus4, merged, lbu_val;
  logic [RW-1:0]  rd_idx;
  logic           rd_ok;
  logic [4:0]     lane_sh;

  assign opc       = inst_q[6:0];
  assign f3        = inst_q[14:12];
  assign f7        = inst_q[31:25];
  assign is_lui    = opc == rvcs_pkg::OP_LUI;
  assign is_add    = opc == rvcs_pkg::OP_ARITH && f3 == rvcs_pkg::F3_ADD
                     && f7 == rvcs_pkg::F7_ADD;
  assign is_addi   = opc == rvcs_pkg::OP_IMM && f3 == rvcs_pkg::F3_ADD;
  assign is_lw     = opc == rvcs_pkg::OP_LOAD && f3 == rvcs_pkg::F3_W;
  assign is_lbu    = opc == rvcs_pkg::OP_LOAD && f3 == rvcs_pkg::F3_BU;
  assign is_sw     = opc == rvcs_pkg::OP_STORE && f3 == rvcs_pkg::F3_W;
  assign is_sb     = opc == rvcs_pkg::OP_STORE && f3 == rvcs_pkg::F3_B;
  assign is_jalr   = opc == rvcs_pkg::OP_JALR && f3 == rvcs_pkg::F3_ADD;
  assign is_ebreak = inst_q == rvcs_pkg::INST_EBREAK;
  assign is_mem    = is_lw || is_lbu || is_sw || is_sb;

  assign immi     = rvcs_pkg::sext12(inst_q[31:20]);
  assign imms     = rvcs_pkg::sext12({inst_q[31:25], inst_q[11:7]});
  assign daddr    = rs1v + ((is_sw || is_sb) ? imms : immi);
  assign pc_plus4 = pc_q + 32'd4;
  assign rd_idx   = rix(inst_q[11:7]);
  assign rd_ok    = rd_idx != '0;
  assign lane_sh  = {daddr[1:0], 3'b000};
  assign merged   = (mem_rdata & ~(32'h0000_00FF << lane_sh))
                    | ({24'd0, rs2v[7:0]} << lane_sh);
  assign lbu_val  = (mem_rdata >> lane_sh) & 32'h0000_00FF;

  assign cnt_ok   = cnt_q >= AguLat;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (state_q)
      S_FADDR: agu_word = pc_q[31:2];
      S_HADDR: agu_word = {20'd0, req_q.host_addr};
      default: agu_word = daddr[31:2];
    endcase
  end

  rvcs_agu #(.MemWords(MemWords)) u_agu (
    .clk_i  (clk_i),
    .word_i (agu_word),
    .idx_o  (agu_idx)
  );

  rvcs_wmem #(.MemWords(MemWords)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rvcs_rf #(.RegCount(RegCount)) u_rf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (rf_we),
    .waddr_i  (rf_waddr),
    .wdata_i  (rf_wdata),
    .re_i     (rf_re),
    .raddr1_i (rf_raddr1),
    .raddr2_i (rf_raddr2),
    .rdata1_o (rs1v),
    .rdata2_o (rs2v)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_ok ? cnt_q : cnt_q + 2'd1;
    clr_d     = clr_q;
    pc_d      = pc_q;
    halt_d    = halt_q;
    inst_d    = inst_q;
    widx_d    = widx_q;
    fin       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = agu_idx;
    mem_wdata = req_q.host_data;
    mem_re    = 1'b0;
    mem_raddr = agu_idx;
    rf_we     = 1'b0;
    rf_waddr  = rd_idx;
    rf_wdata  = mem_rdata;
    rf_re     = 1'b0;
    rf_raddr1 = rix(mem_rdata[19:15]);
    // EBREAK reads a0 on the second port for the trap report
    rf_raddr2 = (mem_rdata == rvcs_pkg::INST_EBREAK) ? A0Idx : rix(mem_rdata[24:20]);
    res       = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 32'd0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
      end
      S_FADDR: begin
        if (cnt_ok) begin
          mem_re  = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        rf_re   = 1'b1;
        inst_d  = mem_rdata;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (is_mem) begin
          state_d = S_DWAIT;
          cnt_d   = 2'd1;
        end else if (out_free) begin
          fin              = 1'b1;
          state_d          = S_IDLE;
          res.fetched_inst = inst_q;
          pc_d             = pc_plus4;
          priority if (is_lui) begin
            rf_we    = rd_ok;
            rf_wdata = {inst_q[31:12], 12'd0};
          end else if (is_add) begin
            rf_we    = rd_ok;
            rf_wdata = rs1v + rs2v;
          end else if (is_addi) begin
            rf_we    = rd_ok;
            rf_wdata = rs1v + immi;
          end else if (is_jalr) begin
            rf_we    = rd_ok;
            rf_wdata = pc_plus4;
            pc_d     = {daddr[31:1], 1'b0};
          end else if (is_ebreak) begin
            halt_d        = 1'b1;
            pc_d          = pc_q;
            res.trap_code = (rs2v == 32'd0) ? rvcs_pkg::TRAP_GOOD : rvcs_pkg::TRAP_BAD;
          end else begin
            res.unknown_inst = 1'b1;
          end
        end
      end
      S_DWAIT: begin
        if (cnt_ok) begin
          if (is_sw) begin
            if (out_free) begin
              fin              = 1'b1;
              state_d          = S_IDLE;
              res.fetched_inst = inst_q;
              pc_d             = pc_plus4;
              mem_we           = 1'b1;
              mem_wdata        = rs2v;
            end
          end else begin
            mem_re  = 1'b1;
            widx_d  = agu_idx;
            state_d = S_MEM;
          end
        end
      end
      S_MEM: begin
        if (out_free) begin
          fin              = 1'b1;
          state_d          = S_IDLE;
          res.fetched_inst = inst_q;
          pc_d             = pc_plus4;
          if (is_sb) begin
            mem_we    = 1'b1;
            mem_waddr = widx_q;
            mem_wdata = merged;
          end else begin
            rf_we    = rd_ok;
            rf_wdata = is_lbu ? lbu_val : mem_rdata;
          end
        end
      end
      S_HADDR: begin
        if (cnt_ok) begin
          if (req_q.func == rvcs_pkg::FUNC_HWRITE) begin
            if (out_free) begin
              fin     = 1'b1;
              state_d = S_IDLE;
              mem_we  = 1'b1;
            end
          end else begin
            mem_re  = 1'b1;
            state_d = S_HREAD;
          end
        end
      end
      S_HREAD: begin
        if (out_free) begin
          fin           = 1'b1;
          state_d       = S_IDLE;
          res.read_data = mem_rdata;
        end
      end
      S_NOP: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.pc_now    = pc_d;
    res.is_halted = halt_d;

    // take the next word in the cycle the current result is registered
    in_ready = (state_q == S_IDLE) || fin;
    in_fire  = in_valid_i && in_ready;
    if (in_fire) begin
      cnt_d = 2'd0;
      priority if (in_word_i.func == rvcs_pkg::FUNC_EXEC && !halt_d) begin
        state_d = S_FADDR;
      end else if (in_word_i.func == rvcs_pkg::FUNC_HWRITE
                   || in_word_i.func == rvcs_pkg::FUNC_HREAD) begin
        state_d = S_HADDR;
      end else begin
        state_d = S_NOP;
      end
    end
  end

  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= 2'd0;
      clr_q       <= '0;
      pc_q        <= 32'd0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q <= inst_d;
    widx_q <= widx_d;
    if (in_fire) begin
      req_q <= in_word_i;
    end
    if (fin) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_mem_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("word memory read and written in the same cycle");

  a_rf_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rf_we && rf_re))
    else $error("register file read and written in the same cycle");

  a_rf_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> rf_waddr != '0)
    else $error("write to x0");

  a_halt_no_rf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> !rf_we)
    else $error("register write while halted");

  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> pc_q == $past(pc_q))
    else $error("pc moved while halted");

endmodule

`default_nettype wire

@@ hdl/rvcs_agu.sv @@
// ----------------------------------------------------------------------------
// rvcs_agu: word index unit
// Reduces a 30-bit word number modulo the memory depth. A power-of-two depth
// is a plain mask; any other depth uses a two-stage reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcs_agu #(
  parameter int unsigned MemWords = rvcs_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic [29:0]                 word_i,
  output logic      [$clog2(MemWords)-1:0] idx_o
);

  localparam int unsigned AW = $clog2(MemWords);

  if (rvcs_pkg::is_pow2(MemWords)) begin : g_mask
    assign idx_o = word_i[AW-1:0];
  end else begin : g_recip
    // exact floor division for 30-bit values: m = ceil(2^(30+l) / d)
    localparam int unsigned Sh  = 30 + AW;
    localparam logic [63:0] Mul = ((64'd1 << Sh) + 64'(MemWords) - 64'd1) / 64'(MemWords);

    logic [29:0]   word_q;
    logic [29:0]   quot_q;
    logic [AW-1:0] idx_q;
    logic [61:0]   prod;
    logic [61:0]   prod_sh;
    logic [29:0]   rem;

    assign prod    = {32'd0, word_i} * {30'd0, Mul[31:0]};
    assign prod_sh = prod >> Sh;
    assign rem     = word_q - 30'(quot_q * 30'(MemWords));

    always_ff @(posedge clk_i) begin
      word_q <= word_i;
      quot_q <= prod_sh[29:0];
      idx_q  <= rem[AW-1:0];
    end

    assign idx_o = idx_q;
  end

endmodule

`default_nettype wire

@@ hdl/rvcs_wmem.sv @@
// ----------------------------------------------------------------------------
// rvcs_wmem: word memory
// Single write port, single read port, registered read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcs_wmem #(
  parameter int unsigned MemWords = rvcs_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [$clog2(MemWords)-1:0] waddr_i,
  input  wire logic [31:0]                 wdata_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(MemWords)-1:0] raddr_i,
  output logic      [31:0]                 rdata_o
);

  logic [31:0] mem_q [MemWords];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/rvcs_rf.sv @@
// ----------------------------------------------------------------------------
// rvcs_rf: register file
// One write port, two registered read ports. Per-entry valid bits make every
// register read as zero after reset until it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module rvcs_rf #(
  parameter int unsigned RegCount = rvcs_pkg::REG_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [$clog2(RegCount)-1:0] waddr_i,
  input  wire logic [31:0]                 wdata_i,
  input  wire logic                        re_i,
  input  wire logic [$clog2(RegCount)-1:0] raddr1_i,
  input  wire logic [$clog2(RegCount)-1:0] raddr2_i,
  output logic      [31:0]                 rdata1_o,
  output logic      [31:0]                 rdata2_o
);

  logic [31:0]         regs_q [RegCount];
  logic [RegCount-1:0] valid_q;
  logic [31:0]         rdata1_q;
  logic [31:0]         rdata2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      regs_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata1_q <= valid_q[raddr1_i] ? regs_q[raddr1_i] : 32'd0;
      rdata2_q <= valid_q[raddr2_i] ? regs_q[raddr2_i] : 32'd0;
    end
  end

  assign rdata1_o = rdata1_q;
  assign rdata2_o = rdata2_q;

endmodule

`default_nettype wire

@@ verif/tb_rv32e_subset_core_step.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32e_subset_core_step: self-checking bench for the RV32E-subset core step
// Loads programs through host writes, steps the core and reads memory back over
// the valid/stall ports; every result word is checked against a core model.
// ----------------------------------------------------------------------------

module tb_rv32e_subset_core_step;

  localparam realtime     CLK_HALF     = 6.0;
  localparam int unsigned MEM_DEPTH    = 1024;
  localparam int unsigned ITEM_TARGET  = 1250;
  localparam int unsigned QUIET_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RX_HOLD_LEN  = 300;
  localparam int unsigned RING_DEPTH   = 16;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [2:0] F3_JALR   = 3'd0;
  localparam logic [6:0] F7_SUB    = 7'h20;

  typedef enum int {
    IK_LUI, IK_ADD, IK_ADDI, IK_LW, IK_LBU, IK_SW, IK_SB, IK_JUNK, IK_JALR
  } inst_kind_e;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  rvcs_pkg::in_t  in_word   = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  rvcs_pkg::out_t out_word;

  // core model state
  logic [31:0] core_pc;
  logic [31:0] core_regs [16];
  logic [31:0] core_mem [MEM_DEPTH];
  logic        core_halted;

  // expected result words, oldest at exp_head
  rvcs_pkg::out_t exp_ring [RING_DEPTH];
  logic [3:0]     exp_head   = 4'd0;
  logic [3:0]     exp_tail   = 4'd0;
  int unsigned    err_count  = 0;
  int unsigned    items_sent = 0;
  bit             idle_on    = 1'b1;
  bit             quiet      = 1'b0;
  int unsigned    rx_hold    = 0;

  always #(CLK_HALF) clk_i = ~clk_i;

  rv32e_subset_core_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  function automatic void write_reg(input logic [3:0] idx, input logic [31:0] v);
    if (idx != 4'd0) core_regs[idx] = v;
  endfunction

  function automatic rvcs_pkg::out_t core_step(input rvcs_pkg::in_t w);
    rvcs_pkg::out_t r;
    logic [31:0]    inst, a, next, immi, imms;
    logic [6:0]     opc, f7;
    logic [2:0]     f3;
    logic [3:0]     rd, rs1, rs2;
    logic [9:0]     wi;
    logic [4:0]     sh;
    logic           advance;
    r = '0;
    if (w.func == rvcs_pkg::FUNC_HWRITE) begin
      core_mem[w.host_addr] = w.host_data;
    end else if (w.func == rvcs_pkg::FUNC_HREAD) begin
      r.read_data = core_mem[w.host_addr];
    end else if (w.func == rvcs_pkg::FUNC_EXEC && !core_halted) begin
      inst    = core_mem[core_pc[11:2]];
      opc     = inst[6:0];
      f3      = inst[14:12];
      f7      = inst[31:25];
      rd      = inst[10:7];
      rs1     = inst[18:15];
      rs2     = inst[23:20];
      immi    = {{20{inst[31]}}, inst[31:20]};
      imms    = {{20{inst[31]}}, inst[31:25], inst[11:7]};
      next    = core_pc + 32'd4;
      advance = 1'b1;
      r.fetched_inst = inst;
      if (opc == rvcs_pkg::OP_LUI) begin
        write_reg(rd, {inst[31:12], 12'h000});
      end else if (opc == rvcs_pkg::OP_ARITH && f3 == rvcs_pkg::F3_ADD
                   && f7 == rvcs_pkg::F7_ADD) begin
        write_reg(rd, core_regs[rs1] + core_regs[rs2]);
      end else if (opc == rvcs_pkg::OP_IMM && f3 == rvcs_pkg::F3_ADD) begin
        write_reg(rd, core_regs[rs1] + immi);
      end else if (opc == rvcs_pkg::OP_LOAD
                   && (f3 == rvcs_pkg::F3_W || f3 == rvcs_pkg::F3_BU)) begin
        a  = core_regs[rs1] + immi;
        wi = a[11:2];
        sh = {a[1:0], 3'b000};
        if (f3 == rvcs_pkg::F3_W) write_reg(rd, core_mem[wi]);
        else write_reg(rd, (core_mem[wi] >> sh) & 32'h0000_00FF);
      end else if (opc == rvcs_pkg::OP_STORE
                   && (f3 == rvcs_pkg::F3_W || f3 == rvcs_pkg::F3_B)) begin
        a  = core_regs[rs1] + imms;
        wi = a[11:2];
        sh = {a[1:0], 3'b000};
        if (f3 == rvcs_pkg::F3_W) begin
          core_mem[wi] = core_regs[rs2];
        end else begin
          // merge one byte lane
          core_mem[wi] = (core_mem[wi] & ~(32'h0000_00FF << sh)) |
                         ({24'h0, core_regs[rs2][7:0]} << sh);
        end
      end else if (opc == rvcs_pkg::OP_JALR && f3 == F3_JALR) begin
        a = (core_regs[rs1] + immi) & ~32'd1;
        write_reg(rd, core_pc + 32'd4);
        next = a;
      end else if (inst == rvcs_pkg::INST_EBREAK) begin
        core_halted = 1'b1;
        advance     = 1'b0;
        r.trap_code = (core_regs[4'(rvcs_pkg::A0_INDEX)] == 32'd0) ? rvcs_pkg::TRAP_GOOD
                                                                   : rvcs_pkg::TRAP_BAD;
      end else begin
        r.unknown_inst = 1'b1;
      end
      if (advance) core_pc = next;
    end
    r.pc_now    = core_pc;
    r.is_halted = core_halted;
    return r;
  endfunction

  function automatic rvcs_pkg::in_t mk_word(input logic [1:0] f, input logic [9:0] addr,
                                            input logic [31:0] data);
    rvcs_pkg::in_t w;
    w.func      = f;
    w.host_addr = addr;
    w.host_data = data;
    return w;
  endfunction

  function automatic logic [31:0] rand_inst(input bit allow_jump);
    inst_kind_e  k;
    logic [4:0]  rd, rs1, rs2;
    logic [11:0] imm;
    logic [31:0] rnd, w;
    rnd = $urandom();
    rd  = 5'($urandom_range(0, 31));
    rs1 = 5'($urandom_range(0, 31));
    rs2 = 5'($urandom_range(0, 31));
    imm = 12'($urandom_range(0, 4095));
    // bias toward absolute addresses and small offsets
    if ($urandom_range(0, 3) == 0) rs1 = 5'd0;
    if ($urandom_range(0, 3) == 0) imm = 12'($urandom_range(0, 63));
    k = inst_kind_e'($urandom_range(0, allow_jump ? 8 : 7));
    case (k)
      IK_LUI:  w = {rnd[31:12], rd, rvcs_pkg::OP_LUI};
      IK_ADD:  w = {rvcs_pkg::F7_ADD, rs2, rs1, rvcs_pkg::F3_ADD, rd, rvcs_pkg::OP_ARITH};
      IK_ADDI: w = {imm, rs1, rvcs_pkg::F3_ADD, rd, rvcs_pkg::OP_IMM};
      IK_LW:   w = {imm, rs1, rvcs_pkg::F3_W, rd, rvcs_pkg::OP_LOAD};
      IK_LBU:  w = {imm, rs1, rvcs_pkg::F3_BU, rd, rvcs_pkg::OP_LOAD};
      IK_SW:   w = {imm[11:5], rs2, rs1, rvcs_pkg::F3_W, imm[4:0], rvcs_pkg::OP_STORE};
      IK_SB:   w = {imm[11:5], rs2, rs1, rvcs_pkg::F3_B, imm[4:0], rvcs_pkg::OP_STORE};
      IK_JALR: w = {imm, rs1, F3_JALR, rd, rvcs_pkg::OP_JALR};
      default: begin
        // near misses: a fully random word, or a legal opcode with random fields
        if (rnd[0]) w = rnd;
        else begin
          case (rnd[3:1])
            3'd0:    w = {rnd[31:7], rvcs_pkg::OP_ARITH};
            3'd1:    w = {rnd[31:7], rvcs_pkg::OP_IMM};
            3'd2:    w = {rnd[31:7], rvcs_pkg::OP_LOAD};
            3'd3:    w = {rnd[31:7], rvcs_pkg::OP_STORE};
            3'd4:    w = {rnd[31:7], rvcs_pkg::OP_JALR};
            default: w = {rnd[31:7], rvcs_pkg::OP_LUI};
          endcase
        end
        if (w == rvcs_pkg::INST_EBREAK) w = w ^ 32'h0000_1000;
      end
    endcase
    return w;
  endfunction

  task automatic send_word(input rvcs_pkg::in_t w);
    int unsigned gap;
    gap = 0;
    if (idle_on && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    exp_ring[exp_tail] = core_step(w);
    exp_tail = exp_tail + 4'd1;
    if (w.func != FUNC_NONE) items_sent++;
  endtask

  // drop valid, then hold until every result word is back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (exp_head == exp_tail);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_program_burst();
    int unsigned k;
    logic [9:0]  at;
    k  = $urandom_range(1, 8);
    at = core_pc[11:2];
    for (int i = 0; i < k; i++)
      send_word(mk_word(rvcs_pkg::FUNC_HWRITE, at + 10'(i), rand_inst(i == k - 1)));
    for (int i = 0; i < k; i++)
      send_word(mk_word(rvcs_pkg::FUNC_EXEC, 10'($urandom()), $urandom()));
  endtask

  task automatic send_random_mix();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) run_program_burst();
    else if (pick < 75)
      send_word(mk_word(rvcs_pkg::FUNC_HWRITE, 10'($urandom()), $urandom()));
    else if (pick < 87)
      send_word(mk_word(rvcs_pkg::FUNC_HREAD, 10'($urandom()), $urandom()));
    else if (pick < 97)
      send_word(mk_word(rvcs_pkg::FUNC_EXEC, 10'($urandom()), $urandom()));
    else send_word(mk_word(FUNC_NONE, 10'($urandom()), $urandom()));
  endtask

  task automatic test_host_ports();
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, 10'h000, 32'hFFFF_FFFF));
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, 10'h3FF, 32'h0000_0000));
    send_word(mk_word(rvcs_pkg::FUNC_HREAD,  10'h000, 32'h0000_0000));
    send_word(mk_word(rvcs_pkg::FUNC_HREAD,  10'h3FF, 32'hFFFF_FFFF));
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, 10'h3FF, 32'hA5C3_0F81));
    send_word(mk_word(rvcs_pkg::FUNC_HREAD,  10'h3FF, 32'h0000_0000));
    send_word(mk_word(FUNC_NONE,             10'h2AA, 32'h5555_AAAA));
  endtask

  task automatic test_instructions();
    logic [31:0] prog [14];
    prog[0]  = {20'hFFFFF, 5'd1, rvcs_pkg::OP_LUI};
    prog[1]  = {12'hFFF, 5'd0, rvcs_pkg::F3_ADD, 5'd2, rvcs_pkg::OP_IMM};
    // rd 19 aliases x3
    prog[2]  = {rvcs_pkg::F7_ADD, 5'd2, 5'd1, rvcs_pkg::F3_ADD, 5'd19, rvcs_pkg::OP_ARITH};
    prog[3]  = {12'h005, 5'd2, rvcs_pkg::F3_ADD, 5'd0, rvcs_pkg::OP_IMM};
    prog[4]  = {12'h401, 5'd0, rvcs_pkg::F3_ADD, 5'd4, rvcs_pkg::OP_IMM};
    // misaligned word store ignores the lane bits
    prog[5]  = {7'h00, 5'd2, 5'd4, rvcs_pkg::F3_W, 5'd2, rvcs_pkg::OP_STORE};
    prog[6]  = {7'h00, 5'd4, 5'd4, rvcs_pkg::F3_B, 5'd0, rvcs_pkg::OP_STORE};
    prog[7]  = {12'hFFF, 5'd4, rvcs_pkg::F3_W, 5'd5, rvcs_pkg::OP_LOAD};
    prog[8]  = {12'h000, 5'd20, rvcs_pkg::F3_BU, 5'd6, rvcs_pkg::OP_LOAD};
    prog[9]  = {12'h002, 5'd4, rvcs_pkg::F3_BU, 5'd7, rvcs_pkg::OP_LOAD};
    // negative address wraps to the top word
    prog[10] = {12'hFFC, 5'd0, rvcs_pkg::F3_W, 5'd8, rvcs_pkg::OP_LOAD};
    prog[11] = {F7_SUB, 5'd2, 5'd1, rvcs_pkg::F3_ADD, 5'd12, rvcs_pkg::OP_ARITH};
    // odd target: bit 0 cleared, bit 1 left for the fetch to ignore
    prog[12] = {12'h037, 5'd0, F3_JALR, 5'd9, rvcs_pkg::OP_JALR};
    prog[13] = {12'h000, 5'd9, rvcs_pkg::F3_ADD, 5'd11, rvcs_pkg::OP_IMM};
    for (int i = 0; i < 14; i++)
      send_word(mk_word(rvcs_pkg::FUNC_HWRITE, 10'(i), prog[i]));
    for (int i = 0; i < 15; i++)
      send_word(mk_word(rvcs_pkg::FUNC_EXEC, 10'h000, 32'h0000_0000));
  endtask

  task automatic test_backpressure();
    wait_drained();
    idle_on = 1'b0;
    rx_hold = RX_HOLD_LEN;
    repeat (30) send_random_mix();
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random(input int unsigned upto);
    while (items_sent < upto) begin
      if ($urandom_range(0, 99) == 0) idle_on = ~idle_on;
      send_random_mix();
    end
  endtask

  // halting is terminal, so this runs last
  task automatic test_halt();
    logic [9:0]  at;
    logic [31:0] set_a0;
    at     = core_pc[11:2];
    set_a0 = {11'd0, 1'($urandom_range(0, 1)), 5'd0, rvcs_pkg::F3_ADD, 5'd10,
              rvcs_pkg::OP_IMM};
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, at, set_a0));
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, at + 10'd1, rvcs_pkg::INST_EBREAK));
    repeat (3) send_word(mk_word(rvcs_pkg::FUNC_EXEC, 10'h000, 32'h0000_0000));
    send_word(mk_word(rvcs_pkg::FUNC_HWRITE, at + 10'd2, $urandom()));
    send_word(mk_word(rvcs_pkg::FUNC_HREAD, at + 10'd2, 32'h0000_0000));
    send_word(mk_word(FUNC_NONE, 10'h155, 32'hFFFF_FFFF));
    send_word(mk_word(rvcs_pkg::FUNC_EXEC, 10'h3FF, 32'hFFFF_FFFF));
  endtask

  initial begin : rx_stall_gen
    int unsigned burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        rx_hold--;
        out_stall <= 1'b1;
      end else if (burst != 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && !quiet && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      err_count++;
      $error("%s: expected %h, got %h", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rvcs_pkg::out_t exp_w;
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (exp_head == exp_tail) begin
        err_count++;
        $error("result word with nothing expected: %h", out_word);
      end else begin
        exp_w    = exp_ring[exp_head];
        exp_head = exp_head + 4'd1;
        check_field("pc_now", exp_w.pc_now, out_word.pc_now);
        check_field("fetched_inst", exp_w.fetched_inst, out_word.fetched_inst);
        check_field("is_halted", 32'(exp_w.is_halted), 32'(out_word.is_halted));
        check_field("trap_code", 32'(exp_w.trap_code), 32'(out_word.trap_code));
        check_field("unknown_inst", 32'(exp_w.unknown_inst), 32'(out_word.unknown_inst));
        check_field("read_data", exp_w.read_data, out_word.read_data);
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("tb_rv32e_subset_core_step: errors");
    $finish;
  end

  initial begin : main_seq
    core_pc     = 32'd0;
    core_halted = 1'b0;
    for (int i = 0; i < 16; i++) core_regs[i] = 32'd0;
    for (int i = 0; i < MEM_DEPTH; i++) core_mem[i] = 32'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_host_ports();
    test_instructions();
    test_backpressure();
    test_random(ITEM_TARGET - QUIET_ITEMS);
    quiet = 1'b1;
    test_random(ITEM_TARGET);
    test_halt();
    wait_drained();
    if (err_count == 0) begin
      $display("tb_rv32e_subset_core_step: clean");
    end else begin
      $display("tb_rv32e_subset_core_step: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rvcs_pkg.sv
hdl/rvcs_agu.sv
hdl/rvcs_wmem.sv
hdl/rvcs_rf.sv
hdl/rv32e_subset_core_step.sv
verif/tb_rv32e_subset_core_step.sv
